[rtl/core/wzkd_pkg.sv]
// shared types and constants for the window z-score kill decider
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package wzkd_pkg;

    // default window length in samples
    localparam int WINDOW_LEN_DEF = 30;

    // payload widths
    localparam int SAMPLE_W = 15;
    localparam int PID_W    = 22;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_KILL_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_ENABLE    = 4'd1;

    // 80.0 percent in Q7.8
    localparam logic [SAMPLE_W-1:0] KILL_THRESHOLD_RESET = 15'd20480;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PROD,
        ST_SQR,
        ST_TEST
    } state_t;

    // per-step strobes from the sequencer to the lanes
    typedef struct packed {
        logic accept;
        logic sum_en;
        logic prod_en;
        logic sqr_en;
        logic full;
    } lane_ctrl_t;

    // per-channel findings handed to the merge stage
    typedef struct packed {
        logic cpu;
        logic mem;
    } lane_flags_t;

endpackage

`default_nettype wire

[rtl/core/wzkd_lane.sv]
// one channel lane: window memory, running sums and the exact z-score test
// depends on wzkd_pkg
`default_nettype none

module wzkd_lane #(
    parameter int WINDOW_LEN = wzkd_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire wzkd_pkg::lane_ctrl_t              ctrl,
    input  wire logic [wzkd_pkg::SAMPLE_W-1:0]     sample,
    input  wire logic [$clog2(WINDOW_LEN)-1:0]     slot,
    input  wire logic [$clog2(WINDOW_LEN+1)-1:0]   count,
    output logic                                   anomaly
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN+1);
    localparam int X_W    = wzkd_pkg::SAMPLE_W;
    localparam int XSQ_W  = 2 * X_W;
    localparam int SUM_W  = X_W + SLOT_W;
    localparam int SQ_W   = XSQ_W + SLOT_W;
    localparam int NX_W   = CNT_W + X_W;
    localparam int D_W    = NX_W + 1;
    localparam int DD_W   = 2 * NX_W;
    localparam int V_W    = CNT_W + SQ_W;
    localparam int CMP_W  = (DD_W > V_W + 2) ? DD_W : V_W + 2;

    logic [X_W-1:0]          win_mem [WINDOW_LEN];
    logic [X_W-1:0]          old_reg;
    logic [X_W-1:0]          x_reg;
    logic [XSQ_W-1:0]        xsq_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic [SQ_W-1:0]         sq_reg;
    logic [SQ_W-1:0]         sq_next;
    logic [NX_W-1:0]         nx_reg;
    logic signed [D_W-1:0]   d_reg;
    logic [V_W-1:0]          nq_reg;
    logic [2*SUM_W-1:0]      ss_reg;
    logic [V_W-1:0]          v_reg;
    logic [DD_W-1:0]         dd_reg;
    logic                    dpos_reg;
    logic [X_W-1:0]          old_term;
    logic [XSQ_W-1:0]        old_sq_term;

    // window memory: read the leaving sample and write the new one at one slot
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            old_reg       <= win_mem[slot];
            win_mem[slot] <= sample;
        end
    end

    // latch the sample and its square
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x_reg   <= sample;
            xsq_reg <= XSQ_W'(sample) * XSQ_W'(sample);
        end
    end

    // running sums drop the leaving sample once the window is full
    always_comb
    begin
        old_term    = ctrl.full ? old_reg : '0;
        old_sq_term = XSQ_W'(old_term) * XSQ_W'(old_term);
        sum_next    = sum_reg - SUM_W'(old_term) + SUM_W'(x_reg);
        sq_next     = sq_reg - SQ_W'(old_sq_term) + SQ_W'(xsq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
        end
    end

    // n*x alongside the sum update
    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
            nx_reg <= NX_W'(count) * NX_W'(x_reg);
    end

    // d = n*x - S, n*Q and S*S
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            d_reg  <= signed'({1'b0, nx_reg}) - signed'(D_W'(sum_reg));
            nq_reg <= V_W'(count) * V_W'(sq_reg);
            ss_reg <= (2*SUM_W)'(sum_reg) * (2*SUM_W)'(sum_reg);
        end
    end

    // v = n*Q - S*S and d squared
    always_ff @(posedge clk)
    begin
        if (ctrl.sqr_en)
        begin
            v_reg    <= nq_reg - V_W'(ss_reg);
            dpos_reg <= (d_reg > 0);
            dd_reg   <= DD_W'(d_reg[D_W-2:0]) * DD_W'(d_reg[D_W-2:0]);
        end
    end

    // exact test d > 0, v > 0, d*d > 4v
    assign anomaly = dpos_reg && (v_reg != '0)
                     && (CMP_W'(dd_reg) > CMP_W'({v_reg, 2'b00}));

endmodule

`default_nettype wire

[rtl/core/wzkd_merge.sv]
// merge stage: combines lane findings into the kill decision and holds the result
// depends on wzkd_pkg
`default_nettype none

module wzkd_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire wzkd_pkg::lane_flags_t         flags,
    input  wire logic [wzkd_pkg::SAMPLE_W-1:0] mem_load,
    input  wire logic [wzkd_pkg::PID_W-1:0]    top_pid,
    input  wire logic                          pid_present,
    input  wire logic [wzkd_pkg::SAMPLE_W-1:0] kill_threshold,
    input  wire logic                          kill_enable,
    input  wire logic                          out_stall,
    output logic                               out_free,
    output logic                               out_valid,
    output logic                               cpu_anomaly,
    output logic                               mem_anomaly,
    output logic                               any_anomaly,
    output logic                               kill_valid,
    output logic [wzkd_pkg::PID_W-1:0]         kill_target,
    output logic                               kill_issue
);

    logic out_valid_reg;
    logic out_valid_next;
    logic any_c;
    logic kv_c;
    logic ki_c;

    // kill decision
    always_comb
    begin
        any_c = flags.cpu | flags.mem;
        kv_c  = any_c && (mem_load >= kill_threshold) && pid_present;
        ki_c  = kv_c && kill_enable && (top_pid > wzkd_pkg::PID_W'(1));
    end

    // output register is free when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cpu_anomaly <= flags.cpu;
            mem_anomaly <= flags.mem;
            any_anomaly <= any_c;
            kill_valid  <= kv_c;
            kill_target <= kv_c ? top_pid : '0;
            kill_issue  <= ki_c;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/core/window_zscore_kill_decider.sv]
// window z-score kill decider: a request passes the sum, product, square and
// test steps of the five-step sequencer, which drives both lanes together; a
// new request is taken only in idle, and the test step waits for a free output
// register. the output register lets the next request in while a result waits.
// rst_n clears sums, fill count, slot, sequencer and out_valid and loads the
// config defaults; the window memory is not cleared and is used only once full.
`default_nettype none

module window_zscore_kill_decider #(
    parameter int WINDOW_LEN = wzkd_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // sample channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [wzkd_pkg::SAMPLE_W-1:0]    cpu_load,
    input  wire logic [wzkd_pkg::SAMPLE_W-1:0]    mem_load,
    input  wire logic [wzkd_pkg::PID_W-1:0]       top_pid,
    input  wire logic                             pid_present,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  cpu_anomaly,
    output logic                                  mem_anomaly,
    output logic                                  any_anomaly,
    output logic                                  kill_valid,
    output logic [wzkd_pkg::PID_W-1:0]            kill_target,
    output logic                                  kill_issue,
    // configuration channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wzkd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wzkd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN+1);

    wzkd_pkg::state_t                state_reg;
    wzkd_pkg::state_t                state_next;
    wzkd_pkg::lane_ctrl_t            ctrl;
    wzkd_pkg::lane_flags_t           flags;
    logic [SLOT_W-1:0]               slot_reg;
    logic [SLOT_W-1:0]               slot_next;
    logic [CNT_W-1:0]                fill_reg;
    logic [CNT_W-1:0]                fill_next;
    logic                            full_reg;
    logic                            accept;
    logic                            load;
    logic                            out_free;
    logic [wzkd_pkg::SAMPLE_W-1:0]   mem_load_reg;
    logic [wzkd_pkg::PID_W-1:0]      pid_reg;
    logic                            present_reg;
    logic [wzkd_pkg::SAMPLE_W-1:0]   kill_threshold_reg;
    logic                            kill_enable_reg;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kill_threshold_reg <= wzkd_pkg::KILL_THRESHOLD_RESET;
            kill_enable_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wzkd_pkg::REG_KILL_THRESHOLD: kill_threshold_reg <= cfg_data;
                wzkd_pkg::REG_KILL_ENABLE:    kill_enable_reg    <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // request handshake
    assign in_stall = (state_reg != wzkd_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wzkd_pkg::ST_IDLE: if (accept) state_next = wzkd_pkg::ST_SUM;
            wzkd_pkg::ST_SUM:  state_next = wzkd_pkg::ST_PROD;
            wzkd_pkg::ST_PROD: state_next = wzkd_pkg::ST_SQR;
            wzkd_pkg::ST_SQR:  state_next = wzkd_pkg::ST_TEST;
            wzkd_pkg::ST_TEST: if (out_free) state_next = wzkd_pkg::ST_IDLE;
            default:           state_next = wzkd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl.accept  = accept;
        ctrl.sum_en  = (state_reg == wzkd_pkg::ST_SUM);
        ctrl.prod_en = (state_reg == wzkd_pkg::ST_PROD);
        ctrl.sqr_en  = (state_reg == wzkd_pkg::ST_SQR);
        ctrl.full    = full_reg;
        load         = (state_reg == wzkd_pkg::ST_TEST) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wzkd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // write slot and fill count
    always_comb
    begin
        slot_next = (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + SLOT_W'(1);
        fill_next = (fill_reg == CNT_W'(WINDOW_LEN)) ? fill_reg : fill_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            full_reg <= (fill_reg == CNT_W'(WINDOW_LEN));
        end
    end

    // fields the merge stage needs later
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_load_reg <= mem_load;
            pid_reg      <= top_pid;
            present_reg  <= pid_present;
        end
    end

    // cpu and memory lanes
    wzkd_lane #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_cpu_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (cpu_load),
        .slot    (slot_reg),
        .count   (fill_reg),
        .anomaly (flags.cpu)
    );

    wzkd_lane #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_mem_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .sample  (mem_load),
        .slot    (slot_reg),
        .count   (fill_reg),
        .anomaly (flags.mem)
    );

    // merge and result register
    wzkd_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .flags          (flags),
        .mem_load       (mem_load_reg),
        .top_pid        (pid_reg),
        .pid_present    (present_reg),
        .kill_threshold (kill_threshold_reg),
        .kill_enable    (kill_enable_reg),
        .out_stall      (out_stall),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .cpu_anomaly    (cpu_anomaly),
        .mem_anomaly    (mem_anomaly),
        .any_anomaly    (any_anomaly),
        .kill_valid     (kill_valid),
        .kill_target    (kill_target),
        .kill_issue     (kill_issue)
    );

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_LEN))
        else $error("fill count beyond window length");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW_LEN - 1))
        else $error("write slot beyond window");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == wzkd_pkg::ST_SUM))
        else $error("accepted request did not start the sequencer");

    a_issue_implies_kill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kill_issue) |-> (kill_valid && kill_target > wzkd_pkg::PID_W'(1)))
        else $error("kill issued without a valid target");

    a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kill_valid) |-> (kill_target == '0))
        else $error("kill target set without a proposal");

endmodule

`default_nettype wire
